[hdl/hrhs_pkg.sv]
package hrhs_pkg;

    localparam int ROUTE_COUNT   = 10;
    localparam int ROUTE_W       = 4;
    localparam int ROUTE_TEXT_MAX = 27;
    localparam int LEN_KEY_SIZE  = 15;
    localparam int CONT_KEY_SIZE = 12;
    localparam int QUEUE_DEPTH   = 4;
    localparam int QUEUE_PTR_W   = 2;
    localparam int QUEUE_CNT_W   = 3;

    localparam logic [ROUTE_W-1:0] ROUTE_NONE = 4'd10;

    localparam logic [0:0] KIND_BYTE  = 1'b0;
    localparam logic [0:0] KIND_START = 1'b1;

    localparam logic [0:0] STATUS_COMPLETE = 1'b0;
    localparam logic [0:0] STATUS_OVERSIZE = 1'b1;

    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
    localparam logic [7:0] CHAR_LOWER_C = 8'h63;
    localparam logic [7:0] CHAR_ONE   = 8'h31;

    localparam logic [8*LEN_KEY_SIZE-1:0]  LEN_KEY  = "content-length:";
    localparam logic [8*CONT_KEY_SIZE-1:0] CONT_KEY = "100-continue";

    // Prefix lengths, in priority order.
    localparam logic [4:0] ROUTE_LEN [ROUTE_COUNT] =
        '{5'd25, 5'd26, 5'd26, 5'd26, 5'd24, 5'd27, 5'd24, 5'd21, 5'd24, 5'd6};

    typedef enum logic [1:0] {
        LEN_SEARCH,
        LEN_BLANKS,
        LEN_DIGITS,
        LEN_DONE
    } len_phase_t;

    typedef struct packed {
        logic       kind;
        logic [7:0] data_byte;
    } item_t;

    typedef struct packed {
        logic                status;
        logic [ROUTE_W-1:0]  route;
        logic [31:0]         body_length;
        logic                expects_continue;
        logic [9:0]          header_length;
    } result_t;

    // One byte after the front has looked at it.
    typedef struct packed {
        logic       kind;
        logic [7:0] data_byte;
        logic [7:0] lower;
        logic       is_digit;
        logic       is_blank;
        logic       is_cr;
        logic       is_lf;
        logic [3:0] digit;
    } class_t;

    // Character p of route prefix r; p must lie below that prefix's length.
    function automatic logic [7:0] route_char(input logic [ROUTE_W-1:0] r,
                                              input logic [4:0] p);
        logic [8*ROUTE_TEXT_MAX-1:0] txt;
        logic [4:0]                  idx;
        unique case (r)
            4'd0:    txt = 216'("POST /api/firmware/upload");
            4'd1:    txt = 216'("GET /api/firmware/download");
            4'd2:    txt = 216'("POST /api/firmware/install");
            4'd3:    txt = 216'("POST /api/firmware/confirm");
            4'd4:    txt = 216'("GET /api/firmware/verify");
            4'd5:    txt = 216'("DELETE /api/firmware/staged");
            4'd6:    txt = 216'("GET /api/firmware/status");
            4'd7:    txt = 216'("GET /api/crash/latest");
            4'd8:    txt = 216'("DELETE /api/crash/latest");
            4'd9:    txt = 216'("GET / ");
            default: txt = '0;
        endcase
        // Strings are right-aligned, so the first character sits highest.
        if (r < ROUTE_NONE)
            idx = ROUTE_LEN[r] - 5'd1 - p;
        else
            idx = '0;
        return txt[8*idx +: 8];
    endfunction

    function automatic logic [7:0] len_key_char(input logic [3:0] p);
        logic [3:0] idx;
        idx = 4'(LEN_KEY_SIZE - 1) - p;
        return LEN_KEY[8*idx +: 8];
    endfunction

    function automatic logic [7:0] cont_key_char(input logic [3:0] p);
        logic [3:0] idx;
        idx = 4'(CONT_KEY_SIZE - 1) - p;
        return CONT_KEY[8*idx +: 8];
    endfunction

endpackage

[hdl/http_request_header_scanner_top.sv]
// Scans an HTTP request header one byte per transfer and delivers one result when the
// header ends at CR LF CR LF or reaches HEADER_BUFFER_BYTES - 1 bytes. The block takes one
// item every cycle while item_stall is low; the scan unit does a byte's work in the cycle it
// pops the byte, and the result of a header's last byte passes through the queue and then
// the result register, and is held back while an earlier result is still waiting there.
// A four-entry queue between the classifier and the scan unit lets input keep flowing while a
// result waits to be taken, until the queue is full. A start item clears all scan state; bytes
// after a finished header are dropped until the next start item.
module http_request_header_scanner_top
    import hrhs_pkg::*;
#(
    parameter int HEADER_BUFFER_BYTES = 1024
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    item_valid,
    output logic    item_stall,
    input  item_t   item,
    output logic    result_valid,
    input  logic    result_stall,
    output result_t result
);

    class_t cls;
    class_t head_data;
    logic   queue_full;
    logic   head_valid;
    logic   pop;

    hrhs_front u_front (
        .item (item),
        .cls  (cls)
    );

    hrhs_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (item_valid),
        .push_data  (cls),
        .full       (queue_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_data  (head_data)
    );

    hrhs_back #(
        .HEADER_BUFFER_BYTES (HEADER_BUFFER_BYTES)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head_valid   (head_valid),
        .head_data    (head_data),
        .pop          (pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    assign item_stall = queue_full;

endmodule

[hdl/hrhs_front.sv]
module hrhs_front
    import hrhs_pkg::*;
(
    input  item_t  item,
    output class_t cls
);

    logic [7:0] b;

    assign b = item.data_byte;

    always_comb
    begin
        cls.kind      = item.kind;
        cls.data_byte = b;
        cls.lower     = (b >= CHAR_UPPER_A && b <= CHAR_UPPER_Z) ? b + 8'd32 : b;
        cls.is_digit  = (b >= CHAR_ZERO) && (b <= CHAR_NINE);
        cls.is_blank  = (b == CHAR_SPACE) || (b == CHAR_TAB);
        cls.is_cr     = (b == CHAR_CR);
        cls.is_lf     = (b == CHAR_LF);
        cls.digit     = 4'(b - CHAR_ZERO);
    end

endmodule

[hdl/hrhs_queue.sv]
module hrhs_queue
    import hrhs_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push,
    input  class_t push_data,
    output logic   full,
    input  logic   pop,
    output logic   head_valid,
    output class_t head_data
);

    class_t                 entry_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg;
    logic [QUEUE_PTR_W-1:0] wr_ptr_next;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg;
    logic [QUEUE_PTR_W-1:0] rd_ptr_next;
    logic [QUEUE_CNT_W-1:0] count_reg;
    logic [QUEUE_CNT_W-1:0] count_next;
    logic                   do_push;
    logic                   do_pop;

    assign full       = (count_reg == QUEUE_CNT_W'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_data  = entry_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + QUEUE_CNT_W'(do_push) - QUEUE_CNT_W'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

[hdl/hrhs_back.sv]
module hrhs_back
    import hrhs_pkg::*;
#(
    parameter int HEADER_BUFFER_BYTES = 1024
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    head_valid,
    input  class_t  head_data,
    output logic    pop,
    output logic    result_valid,
    input  logic    result_stall,
    output result_t result
);

    localparam int CNT_W = $clog2(HEADER_BUFFER_BYTES);
    localparam logic [CNT_W-1:0] BYTE_LIMIT = CNT_W'(HEADER_BUFFER_BYTES - 1);

    logic                   scanning_reg;
    logic                   scanning_next;
    logic [CNT_W-1:0]       count_reg;
    logic [CNT_W-1:0]       count_next;
    logic [1:0]             term_reg;
    logic [1:0]             term_next;
    logic [3:0]             len_key_reg;
    logic [3:0]             len_key_next;
    len_phase_t             phase_reg;
    len_phase_t             phase_next;
    logic [31:0]            acc_reg;
    logic [31:0]            acc_next;
    logic [3:0]             cont_key_reg;
    logic [3:0]             cont_key_next;
    logic                   cont_found_reg;
    logic                   cont_found_next;
    logic [ROUTE_COUNT-1:0] alive_reg;
    logic [ROUTE_COUNT-1:0] alive_next;
    logic                   result_valid_reg;
    logic                   result_valid_next;
    result_t                result_reg;
    result_t                result_next;

    logic                   active;
    logic                   done;
    logic [CNT_W+9:0]       pos_wide;
    logic [CNT_W+9:0]       cnt_wide;
    logic [31:0]            acc_times_ten;
    logic [ROUTE_W-1:0]     route_pick;

    // The back takes a queued entry whenever the result register can hold a new result.
    assign pop          = head_valid && (!result_valid_reg || !result_stall);
    assign active       = pop && (head_data.kind == KIND_BYTE) && scanning_reg;
    assign pos_wide     = {10'd0, count_reg};
    assign cnt_wide     = {10'd0, count_next};
    assign acc_times_ten = {acc_reg[28:0], 3'b000} + {acc_reg[30:0], 1'b0};

    // Route prefix elimination, one comparator per prefix.
    always_comb
    begin
        alive_next = alive_reg;
        for (int r = 0; r < ROUTE_COUNT; r++)
        begin
            if (pos_wide < (CNT_W+10)'(ROUTE_LEN[r]) &&
                head_data.data_byte != route_char(ROUTE_W'(r), pos_wide[4:0]))
            begin
                alive_next[r] = 1'b0;
            end
        end
    end

    // Content-length phase sequencing.
    always_comb
    begin
        phase_next   = phase_reg;
        len_key_next = len_key_reg;
        acc_next     = acc_reg;
        unique case (phase_reg)
            LEN_SEARCH:
            begin
                if (head_data.lower == len_key_char(len_key_reg))
                begin
                    if (len_key_reg == 4'(LEN_KEY_SIZE - 1))
                    begin
                        len_key_next = '0;
                        phase_next   = LEN_BLANKS;
                    end
                    else
                    begin
                        len_key_next = len_key_reg + 4'd1;
                    end
                end
                else
                begin
                    len_key_next = (head_data.lower == CHAR_LOWER_C) ? 4'd1 : 4'd0;
                end
            end
            LEN_BLANKS:
            begin
                if (head_data.is_digit)
                begin
                    acc_next   = {28'd0, head_data.digit};
                    phase_next = LEN_DIGITS;
                end
                else if (!head_data.is_blank)
                begin
                    phase_next = LEN_DONE;
                end
            end
            LEN_DIGITS:
            begin
                if (head_data.is_digit)
                    acc_next = acc_times_ten + {28'd0, head_data.digit};
                else
                    phase_next = LEN_DONE;
            end
            LEN_DONE:
            begin
                phase_next = LEN_DONE;
            end
            default:
            begin
                phase_next = LEN_DONE;
            end
        endcase
    end

    // 100-continue search and the CR LF CR LF terminator.
    always_comb
    begin
        cont_key_next   = cont_key_reg;
        cont_found_next = cont_found_reg;
        if (!cont_found_reg)
        begin
            if (head_data.lower == cont_key_char(cont_key_reg))
            begin
                if (cont_key_reg == 4'(CONT_KEY_SIZE - 1))
                begin
                    cont_key_next   = '0;
                    cont_found_next = 1'b1;
                end
                else
                begin
                    cont_key_next = cont_key_reg + 4'd1;
                end
            end
            else
            begin
                cont_key_next = (head_data.lower == CHAR_ONE) ? 4'd1 : 4'd0;
            end
        end

        done = 1'b0;
        if (head_data.is_cr)
        begin
            term_next = (term_reg == 2'd2) ? 2'd3 : 2'd1;
        end
        else if (head_data.is_lf)
        begin
            if (term_reg == 2'd1)
            begin
                term_next = 2'd2;
            end
            else if (term_reg == 2'd3)
            begin
                term_next = term_reg;
                done      = 1'b1;
            end
            else
            begin
                term_next = 2'd0;
            end
        end
        else
        begin
            term_next = 2'd0;
        end
    end

    assign count_next = count_reg + 1'b1;

    // The first surviving prefix that the header is long enough to contain.
    always_comb
    begin
        route_pick = ROUTE_NONE;
        for (int r = ROUTE_COUNT - 1; r >= 0; r--)
        begin
            if (alive_next[r] && cnt_wide >= (CNT_W+10)'(ROUTE_LEN[r]))
                route_pick = ROUTE_W'(r);
        end
    end

    always_comb
    begin
        scanning_next     = scanning_reg;
        result_next       = result_reg;
        result_valid_next = result_valid_reg && result_stall;
        if (active)
        begin
            if (done)
            begin
                scanning_next                = 1'b0;
                result_valid_next            = 1'b1;
                result_next.status           = STATUS_COMPLETE;
                result_next.route            = route_pick;
                result_next.body_length      = acc_next;
                result_next.expects_continue = cont_found_next;
                result_next.header_length    = cnt_wide[9:0];
            end
            else if (count_next >= BYTE_LIMIT)
            begin
                scanning_next                = 1'b0;
                result_valid_next            = 1'b1;
                result_next.status           = STATUS_OVERSIZE;
                result_next.route            = ROUTE_NONE;
                result_next.body_length      = '0;
                result_next.expects_continue = 1'b0;
                result_next.header_length    = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scanning_reg     <= 1'b1;
            count_reg        <= '0;
            term_reg         <= '0;
            len_key_reg      <= '0;
            phase_reg        <= LEN_SEARCH;
            acc_reg          <= '0;
            cont_key_reg     <= '0;
            cont_found_reg   <= 1'b0;
            alive_reg        <= '1;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            result_valid_reg <= result_valid_next;
            if (pop && head_data.kind == KIND_START)
            begin
                scanning_reg   <= 1'b1;
                count_reg      <= '0;
                term_reg       <= '0;
                len_key_reg    <= '0;
                phase_reg      <= LEN_SEARCH;
                acc_reg        <= '0;
                cont_key_reg   <= '0;
                cont_found_reg <= 1'b0;
                alive_reg      <= '1;
            end
            else if (active)
            begin
                scanning_reg   <= scanning_next;
                count_reg      <= count_next;
                term_reg       <= term_next;
                len_key_reg    <= len_key_next;
                phase_reg      <= phase_next;
                acc_reg        <= acc_next;
                cont_key_reg   <= cont_key_next;
                cont_found_reg <= cont_found_next;
                alive_reg      <= alive_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule
